// File: sv/kmf_pkg.sv
// Shared widths, codes, reset values and types for the key mode and frequency meter.
package kmf_pkg;

  localparam int FREQ_FRAC_BITS = 8;

  localparam int OP_W     = 3;
  localparam int TIME_W   = 32;
  localparam int CYC_W    = 32;
  localparam int MODE_W   = 2;
  localparam int FREQ_W   = 32;
  localparam int CLK_W    = 30;
  localparam int MS_W     = 16;
  localparam int EDGE_W   = 16;
  localparam int CFG_A_W  = 8;
  localparam int CFG_D_W  = 32;

  localparam int PROD_W   = CLK_W + EDGE_W;
  localparam int NUM_W    = PROD_W + FREQ_FRAC_BITS;
  localparam int CNT_W    = $clog2(FREQ_W);

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [FREQ_W-1:0]  freq_t;
  typedef logic [TIME_W-1:0]  ms_t;
  typedef logic [CYC_W-1:0]   cyc_t;
  typedef logic [CFG_A_W-1:0] cfg_addr_t;
  typedef logic [CFG_D_W-1:0] cfg_data_t;

  // event codes
  localparam op_t OP_EDGE = 3'd0;
  localparam op_t OP_UP   = 3'd1;
  localparam op_t OP_DOWN = 3'd2;
  localparam op_t OP_AUTO = 3'd3;

  // modes
  localparam mode_t MODE_BASIC_LOW  = 2'd0;
  localparam mode_t MODE_BASIC_HIGH = 2'd2;
  localparam mode_t MODE_ADVANCED   = 2'd3;

  // register indexes
  localparam cfg_addr_t REG_CLOCK_HZ      = 8'd0;
  localparam cfg_addr_t REG_LOCKOUT_MS    = 8'd1;
  localparam cfg_addr_t REG_MEASURE_EDGES = 8'd2;
  localparam cfg_addr_t REG_RESTART_EDGES = 8'd3;

  // reset values
  localparam logic [CLK_W-1:0]  RST_CLOCK_HZ      = 30'd168000000;
  localparam logic [MS_W-1:0]   RST_LOCKOUT_MS    = 16'd200;
  localparam logic [EDGE_W-1:0] RST_MEASURE_EDGES = 16'd500;
  localparam logic [EDGE_W-1:0] RST_RESTART_EDGES = 16'd10;
  localparam freq_t             RST_FREQ          = freq_t'(5000) << FREQ_FRAC_BITS;

endpackage

// File: sv/kmf_channels.sv
// Valid/ready channel interfaces for events, results and register writes.
interface kmf_in_if;
  import kmf_pkg::*;
  logic valid;
  logic ready;
  op_t  op;
  ms_t  now_ms;
  cyc_t cycle_count;
  modport source (output valid, output op, output now_ms, output cycle_count, input ready);
  modport sink   (input valid, input op, input now_ms, input cycle_count, output ready);
endinterface

interface kmf_out_if;
  import kmf_pkg::*;
  logic  valid;
  logic  ready;
  mode_t mode;
  freq_t freq_q8;
  logic  freq_updated;
  logic  phase_sync;
  modport source (output valid, output mode, output freq_q8, output freq_updated,
                  output phase_sync, input ready);
  modport sink   (input valid, input mode, input freq_q8, input freq_updated,
                  input phase_sync, output ready);
endinterface

interface kmf_cfg_if;
  import kmf_pkg::*;
  logic      valid;
  logic      ready;
  cfg_addr_t addr;
  cfg_data_t data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// File: sv/key_mode_and_freq_meter.sv
// Key mode selector and reciprocal frequency meter, one event transfer at a time.
// Steps: key, ignored and non-capturing edge events go from the transfer straight to staging;
//   a dividing capture runs 16 multiply steps, a range check, 32 divide steps and staging.
//   A saturating capture skips the divide. The next event transfers once the result sits in the
//   output register, later while the sink stalls.
// Reset: rst_n synchronous active low; register defaults, mode/counters/capture cleared, 5000 Hz.
module key_mode_and_freq_meter (
  input  logic       clk,
  input  logic       rst_n,
  kmf_in_if.sink     in_ch,
  kmf_out_if.source  out_ch,
  kmf_cfg_if.sink    cfg_ch
);
  import kmf_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SAT  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // configuration
  logic [CLK_W-1:0]  clock_hz_r;
  logic [MS_W-1:0]   lockout_ms_r;
  logic [EDGE_W-1:0] measure_edges_r;
  logic [EDGE_W-1:0] restart_edges_r;

  // architectural state
  mode_t             mode_r, mode_nxt;
  ms_t               last_key_r, last_key_nxt;
  logic [EDGE_W-1:0] meas_cnt_r, meas_cnt_nxt;
  logic [EDGE_W-1:0] rst_cnt_r, rst_cnt_nxt;
  cyc_t              last_cap_r, last_cap_nxt;
  freq_t             freq_r, freq_nxt;

  // sequencer and datapath
  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  cyc_t              period_r, period_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [EDGE_W-1:0] mplier_r, mplier_nxt;
  logic [FREQ_W-1:0] rem_r, rem_nxt;
  logic [FREQ_W-1:0] quo_r, quo_nxt;
  logic              upd_r, upd_nxt;
  logic              pulse_r, pulse_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  mode_t             out_mode_r;
  freq_t             out_freq_r;
  logic              out_upd_r;
  logic              out_pulse_r;

  logic              in_xfer;
  logic              out_free;
  logic              load_out;

  logic [EDGE_W-1:0] meas_inc;
  logic [EDGE_W-1:0] rst_inc;
  ms_t               since_key;
  logic              key_ok;
  logic [NUM_W-1:0]  num;
  logic [FREQ_W:0]   trial;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign load_out     = (state_r == ST_DONE) && out_free;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.mode          = out_mode_r;
  assign out_ch.freq_q8       = out_freq_r;
  assign out_ch.freq_updated  = out_upd_r;
  assign out_ch.phase_sync    = out_pulse_r;

  // event side arithmetic, used only in the transfer cycle
  assign meas_inc  = meas_cnt_r + EDGE_W'(1);
  assign rst_inc   = rst_cnt_r + EDGE_W'(1);
  assign since_key = in_ch.now_ms - last_key_r;
  assign key_ok    = since_key > TIME_W'(lockout_ms_r);

  // numerator = clock_hz * measure_edges scaled by the fraction bits
  assign num   = NUM_W'(prod_r) << FREQ_FRAC_BITS;
  // one restoring divide step: shift in the next numerator bit, try to subtract the period
  assign trial = {rem_r, quo_r[FREQ_W-1]} - {1'b0, period_r};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    last_key_nxt  = last_key_r;
    meas_cnt_nxt  = meas_cnt_r;
    rst_cnt_nxt   = rst_cnt_r;
    last_cap_nxt  = last_cap_r;
    freq_nxt      = freq_r;
    period_nxt    = period_r;
    prod_nxt      = prod_r;
    mplier_nxt    = mplier_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    upd_nxt       = upd_r;
    pulse_nxt     = pulse_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          upd_nxt   = 1'b0;
          pulse_nxt = 1'b0;
          state_nxt = ST_DONE;
          if (in_ch.op == OP_EDGE) begin
            meas_cnt_nxt = meas_inc;
            if (meas_inc >= measure_edges_r) begin
              meas_cnt_nxt = '0;
              if (last_cap_r != '0) begin
                // start the frequency computation
                upd_nxt    = 1'b1;
                period_nxt = in_ch.cycle_count - last_cap_r;
                prod_nxt   = '0;
                mplier_nxt = measure_edges_r;
                cnt_nxt    = '0;
                state_nxt  = ST_MUL;
              end
              last_cap_nxt = in_ch.cycle_count;
            end
            rst_cnt_nxt = rst_inc;
            if (rst_inc >= restart_edges_r) begin
              rst_cnt_nxt = '0;
              pulse_nxt   = 1'b1;
            end
          end else if ((in_ch.op == OP_UP || in_ch.op == OP_DOWN || in_ch.op == OP_AUTO)
                       && key_ok) begin
            last_key_nxt = in_ch.now_ms;
            priority if (in_ch.op == OP_UP) begin
              mode_nxt = (mode_r < MODE_BASIC_HIGH) ? mode_r + mode_t'(1) : MODE_BASIC_LOW;
            end else if (in_ch.op == OP_DOWN) begin
              mode_nxt = (mode_r > MODE_BASIC_LOW) ? mode_r - mode_t'(1) : MODE_BASIC_HIGH;
            end else begin
              mode_nxt = MODE_ADVANCED;
            end
          end
        end
      end

      ST_MUL: begin
        // MSB-first shift-and-add over the bits of measure_edges
        prod_nxt   = (prod_r << 1) +
                     (mplier_r[EDGE_W-1] ? PROD_W'(clock_hz_r) : PROD_W'(0));
        mplier_nxt = mplier_r << 1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(EDGE_W-1)) begin
          state_nxt = ST_SAT;
        end
      end

      ST_SAT: begin
        // quotient fits in 32 bits only if the numerator's upper part is below the period;
        // a zero period lands here too
        if (FREQ_W'(num[NUM_W-1:FREQ_W]) >= period_r) begin
          freq_nxt  = '1;
          state_nxt = ST_DONE;
        end else begin
          rem_nxt   = FREQ_W'(num[NUM_W-1:FREQ_W]);
          quo_nxt   = num[FREQ_W-1:0];
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        if (!trial[FREQ_W]) begin
          rem_nxt = trial[FREQ_W-1:0];
          quo_nxt = {quo_r[FREQ_W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[FREQ_W-2:0], quo_r[FREQ_W-1]};
          quo_nxt = {quo_r[FREQ_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(FREQ_W-1)) begin
          freq_nxt  = quo_nxt;
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      clock_hz_r      <= RST_CLOCK_HZ;
      lockout_ms_r    <= RST_LOCKOUT_MS;
      measure_edges_r <= RST_MEASURE_EDGES;
      restart_edges_r <= RST_RESTART_EDGES;
      mode_r          <= MODE_BASIC_LOW;
      last_key_r      <= '0;
      meas_cnt_r      <= '0;
      rst_cnt_r       <= '0;
      last_cap_r      <= '0;
      freq_r          <= RST_FREQ;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
      last_key_r  <= last_key_nxt;
      meas_cnt_r  <= meas_cnt_nxt;
      rst_cnt_r   <= rst_cnt_nxt;
      last_cap_r  <= last_cap_nxt;
      freq_r      <= freq_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.addr)
          REG_CLOCK_HZ:      clock_hz_r      <= cfg_ch.data[CLK_W-1:0];
          REG_LOCKOUT_MS:    lockout_ms_r    <= cfg_ch.data[MS_W-1:0];
          REG_MEASURE_EDGES: measure_edges_r <= cfg_ch.data[EDGE_W-1:0];
          REG_RESTART_EDGES: restart_edges_r <= cfg_ch.data[EDGE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath and payload, no reset
  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    period_r <= period_nxt;
    prod_r   <= prod_nxt;
    mplier_r <= mplier_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    upd_r    <= upd_nxt;
    pulse_r  <= pulse_nxt;
    if (load_out) begin
      out_mode_r  <= mode_r;
      out_freq_r  <= freq_r;
      out_upd_r   <= upd_r;
      out_pulse_r <= pulse_r;
    end
  end

endmodule

// File: sv/kmf_checker.sv
// Port-level checker for the key mode and frequency meter, with its bind.
module kmf_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [kmf_pkg::MODE_W-1:0] out_mode,
  input logic [kmf_pkg::FREQ_W-1:0] out_freq_q8,
  input logic                 out_freq_updated,
  input logic                 out_phase_sync
);
  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pend_r;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // events transferred in whose result has not yet transferred out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_r + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mode) && $stable(out_freq_q8)
      && $stable(out_freq_updated) && $stable(out_phase_sync))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result shown with no event outstanding");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 2'd2 |-> !in_xfer || out_xfer)
    else $error("more than two events outstanding");

endmodule

bind key_mode_and_freq_meter kmf_checker u_kmf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_mode          (out_ch.mode),
  .out_freq_q8       (out_ch.freq_q8),
  .out_freq_updated  (out_ch.freq_updated),
  .out_phase_sync    (out_ch.phase_sync)
);

// File: sim/kmf_meter_checker.sv
// Checker for the key mode and frequency meter: watches all channels, predicts and compares.
module kmf_meter_checker (
  input  logic clk,
  input  logic rst_n,
  kmf_in_if    in_mon,
  kmf_out_if   out_mon,
  kmf_cfg_if   cfg_mon,
  output int   errors,
  output int   pending,
  output int   checked,
  output int   freq_updates,
  output int   saturations,
  output int   restarts,
  output int   keys_taken
);
  timeunit 1ns;
  timeprecision 1ps;
  import kmf_pkg::*;

  typedef struct packed {
    mode_t mode;
    freq_t freq_q8;
    logic  freq_updated;
    logic  phase_sync;
  } meter_reading_t;

  // register copies
  logic [CLK_W-1:0]  cfg_clock_hz;
  logic [MS_W-1:0]   cfg_lockout;
  logic [EDGE_W-1:0] cfg_meas_edges;
  logic [EDGE_W-1:0] cfg_restart_edges;

  // meter state
  mode_t             mode_q;
  ms_t               last_key_ms;
  logic [EDGE_W-1:0] meas_cnt;
  logic [EDGE_W-1:0] restart_cnt;
  cyc_t              last_capture;
  freq_t             freq_q;

  meter_reading_t    expected_readings[$];
  meter_reading_t    want;
  meter_reading_t    got;

  // clock_hz * edges / span in fixed point, saturated on zero span or overflow
  function automatic freq_t freq_from_span(input cyc_t span);
    logic [63:0] num;
    logic [63:0] quo;
    if (span == '0) return '1;
    num = (64'(cfg_clock_hz) * 64'(cfg_meas_edges)) << FREQ_FRAC_BITS;
    quo = num / 64'(span);
    if (quo > 64'hFFFF_FFFF) return '1;
    return quo[FREQ_W-1:0];
  endfunction

  function automatic void step_meter(input op_t op, input ms_t stamp, input cyc_t cyc);
    meter_reading_t r;
    r.freq_updated  = 1'b0;
    r.phase_sync    = 1'b0;
    case (op)
      OP_EDGE: begin
        meas_cnt = meas_cnt + 1'b1;
        if (meas_cnt >= cfg_meas_edges) begin
          meas_cnt = '0;
          if (last_capture != '0) begin
            freq_q = freq_from_span(cyc - last_capture);
            r.freq_updated = 1'b1;
          end
          last_capture = cyc;
        end
        restart_cnt = restart_cnt + 1'b1;
        if (restart_cnt >= cfg_restart_edges) begin
          restart_cnt = '0;
          r.phase_sync = 1'b1;
        end
      end
      OP_UP, OP_DOWN, OP_AUTO: begin
        if (ms_t'(stamp - last_key_ms) > ms_t'(cfg_lockout)) begin
          if (op == OP_UP)
            mode_q = (mode_q < MODE_BASIC_HIGH) ? mode_t'(mode_q + 1'b1) : MODE_BASIC_LOW;
          else if (op == OP_DOWN)
            // advanced steps down into the top basic mode
            mode_q = (mode_q > MODE_BASIC_LOW) ? mode_t'(mode_q - 1'b1) : MODE_BASIC_HIGH;
          else
            mode_q = MODE_ADVANCED;
          last_key_ms = stamp;
          keys_taken++;
        end
      end
      default: ;
    endcase
    r.mode    = mode_q;
    r.freq_q8 = freq_q;
    expected_readings.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%08h actual 0x%08h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_clock_hz      = RST_CLOCK_HZ;
      cfg_lockout       = RST_LOCKOUT_MS;
      cfg_meas_edges    = RST_MEASURE_EDGES;
      cfg_restart_edges = RST_RESTART_EDGES;
      mode_q            = MODE_BASIC_LOW;
      last_key_ms       = '0;
      meas_cnt          = '0;
      restart_cnt       = '0;
      last_capture      = '0;
      freq_q            = RST_FREQ;
      expected_readings.delete();
      pending           = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.addr)
          REG_CLOCK_HZ:      cfg_clock_hz      = cfg_mon.data[CLK_W-1:0];
          REG_LOCKOUT_MS:    cfg_lockout       = cfg_mon.data[MS_W-1:0];
          REG_MEASURE_EDGES: cfg_meas_edges    = cfg_mon.data[EDGE_W-1:0];
          REG_RESTART_EDGES: cfg_restart_edges = cfg_mon.data[EDGE_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        step_meter(in_mon.op, in_mon.now_ms, in_mon.cycle_count);
      if (out_mon.valid && out_mon.ready) begin
        got.mode          = out_mon.mode;
        got.freq_q8       = out_mon.freq_q8;
        got.freq_updated  = out_mon.freq_updated;
        got.phase_sync    = out_mon.phase_sync;
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result, expected none actual 0x%h", $time, got);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          check_field("mode", 32'(want.mode), 32'(got.mode));
          check_field("freq_q8", want.freq_q8, got.freq_q8);
          check_field("freq_updated", 32'(want.freq_updated), 32'(got.freq_updated));
          check_field("phase_sync", 32'(want.phase_sync), 32'(got.phase_sync));
          checked++;
          if (want.freq_updated) freq_updates++;
          if (want.freq_updated && want.freq_q8 == '1) saturations++;
          if (want.phase_sync) restarts++;
        end
      end
      pending = expected_readings.size();
    end
  end

endmodule

// File: sim/testbench.sv
// Top of the meter testbench: clock, reset, stimulus, receiver pacing and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kmf_pkg::*;

  // ops 4..7 carry no event
  localparam op_t OP_IGNORED_LO = 3'd4;
  localparam op_t OP_IGNORED_HI = 3'd7;

  // leave margin for the slowest result before register writes
  localparam int DRAIN_CYCLES   = 60;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASES         = 9;
  localparam int ITEMS_PER_PHASE = 200;

  logic clk;
  logic rst_n;

  kmf_in_if  ev_ch ();
  kmf_out_if res_ch ();
  kmf_cfg_if reg_ch ();

  int errors, pending, checked, freq_updates, saturations, restarts, keys_taken;

  // stimulus shaping
  int          in_idle_pct;
  int          out_idle_pct;
  bit          hold_req;
  int unsigned cur_lockout;
  ms_t         now_run;
  cyc_t        cyc_run;

  key_mode_and_freq_meter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (ev_ch),
    .out_ch (res_ch),
    .cfg_ch (reg_ch)
  );

  kmf_meter_checker meter_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (ev_ch),
    .out_mon      (res_ch),
    .cfg_mon      (reg_ch),
    .errors       (errors),
    .pending      (pending),
    .checked      (checked),
    .freq_updates (freq_updates),
    .saturations  (saturations),
    .restarts     (restarts),
    .keys_taken   (keys_taken)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run (~2000 transfers with both sides stalling).
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: ready changes on the falling edge. A hold request parks ready
  // low for a long stretch so the block backs up and stalls its input.
  initial begin
    bit hold_taken;
    hold_taken   = 1'b0;
    res_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      res_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
      @(negedge clk);
    end
  end

  // One event transfer. Entered and left at a falling edge; valid is left
  // high so the next call can either lower it or reuse it in one step.
  task automatic send_event(input op_t op, input ms_t stamp, input cyc_t cyc);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      ev_ch.valid <= 1'b0;
      @(negedge clk);
    end
    ev_ch.valid       <= 1'b1;
    ev_ch.op          <= op;
    ev_ch.now_ms      <= stamp;
    ev_ch.cycle_count <= cyc;
    @(posedge clk);
    while (!ev_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // One register write; valid stays high so writes can follow back to back.
  task automatic write_reg(input cfg_addr_t addr, input cfg_data_t data);
    reg_ch.valid <= 1'b1;
    reg_ch.addr  <= addr;
    reg_ch.data  <= data;
    @(posedge clk);
    while (!reg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic load_config(input int unsigned hz, input int unsigned lock,
                             input int unsigned meas, input int unsigned rst_edges);
    write_reg(REG_CLOCK_HZ, hz);
    write_reg(REG_LOCKOUT_MS, lock);
    write_reg(REG_MEASURE_EDGES, meas);
    write_reg(REG_RESTART_EDGES, rst_edges);
    reg_ch.valid <= 1'b0;
    cur_lockout = lock;
  endtask

  // Wait until every expected result has been seen, then idle for the
  // DRAIN_CYCLES margin.
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int          p;
    int          counted;
    int          r;
    op_t         op;
    ms_t         stamp;
    cyc_t        cyc;
    int unsigned hz, lock, meas, rst_edges;

    rst_n             = 1'b0;
    ev_ch.valid       = 1'b0;
    ev_ch.op          = OP_EDGE;
    ev_ch.now_ms      = '0;
    ev_ch.cycle_count = '0;
    reg_ch.valid      = 1'b0;
    reg_ch.addr       = REG_CLOCK_HZ;
    reg_ch.data       = '0;
    hold_req          = 1'b0;
    in_idle_pct       = 29;
    out_idle_pct      = 54;
    now_run           = '0;
    cyc_run           = '0;
    cur_lockout       = RST_LOCKOUT_MS;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed: small counts so captures and pulses come quickly ----
    load_config(1000, 5, 2, 3);

    // lockout edge: exactly lockout after the last key is still locked out
    send_event(OP_UP,   32'd5,  '0);
    send_event(OP_UP,   32'd6,  '0);
    send_event(OP_DOWN, 32'd11, '0);
    send_event(OP_UP,   32'd20, '0);
    // up wraps from the top basic mode, down wraps from the bottom one
    send_event(OP_UP,   32'd40, '0);
    send_event(OP_DOWN, 32'd60, '0);
    // auto key, then down and up out of advanced
    send_event(OP_AUTO, 32'd80,  '0);
    send_event(OP_DOWN, 32'd100, '0);
    send_event(OP_AUTO, 32'd120, '0);
    send_event(OP_UP,   32'd140, '0);
    // ignored ops with all-ones fields
    send_event(OP_IGNORED_LO, '1, '1);
    send_event(OP_IGNORED_HI, '1, '1);
    // key time wrapping past 2^32
    send_event(OP_AUTO, 32'hFFFF_FFFD, '0);
    send_event(OP_UP,   32'h0000_0003, '0);
    // a zero capture counts as no capture at all
    send_event(OP_EDGE, '0, 32'd123);
    send_event(OP_EDGE, '0, 32'd0);
    send_event(OP_EDGE, '0, 32'd5);
    send_event(OP_EDGE, '0, 32'd1000);
    // zero period saturates
    send_event(OP_EDGE, '0, 32'd7);
    send_event(OP_EDGE, '0, 32'd1000);
    // huge period, then a period across the counter wrap
    send_event(OP_EDGE, '0, 32'd9);
    send_event(OP_EDGE, '0, 32'hFFFF_FFFF);
    send_event(OP_EDGE, '0, 32'd11);
    send_event(OP_EDGE, '0, 32'd999);
    send_event(OP_EDGE, '0, 32'd1000);
    ev_ch.valid <= 1'b0;
    drain();

    // ---- random phases: one register setting each ----
    for (p = 0; p < PHASES; p++) begin
      // pacing: sender idles less than receiver, then the reverse, then none
      case (p / 3)
        0:       begin in_idle_pct = 29; out_idle_pct = 54; end
        1:       begin in_idle_pct = 54; out_idle_pct = 29; end
        default: begin in_idle_pct = 0;  out_idle_pct = 0;  end
      endcase
      case (p)
        0: begin hz = 1000000000; lock = 0;     meas = 1;     rst_edges = 1;     end
        1: begin hz = 1;          lock = 65535; meas = 65535; rst_edges = 65535; end
        2: begin hz = 0;          lock = 0;     meas = 0;     rst_edges = 0;     end
        3: begin hz = 30'h3FFF_FFFF; lock = 1;  meas = 2;     rst_edges = 7;     end
        4: begin hz = RST_CLOCK_HZ; lock = RST_LOCKOUT_MS; meas = 5;
                 rst_edges = RST_RESTART_EDGES; end
        default: begin
          hz        = $urandom_range(1, 1000000000);
          lock      = $urandom_range(0, 300);
          meas      = $urandom_range(1, 12);
          rst_edges = $urandom_range(1, 20);
        end
      endcase
      load_config(hz, lock, meas, rst_edges);

      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        // long receiver stall while the sender keeps offering
        if (p == 1 && counted == 100) hold_req = 1'b1;
        r = $urandom_range(0, 99);
        now_run = now_run + ms_t'($urandom_range(0, 2 * cur_lockout + 2));
        if (r < 65) begin
          op = OP_EDGE;
          // mostly plausible spans, with zero, tiny and wild steps mixed in
          case ($urandom_range(0, 9))
            0:       cyc_run = cyc_run;
            1:       cyc_run = cyc_run + cyc_t'($urandom_range(1, 64));
            2:       cyc_run = $urandom;
            default: cyc_run = cyc_run + cyc_t'($urandom_range(1, 65536));
          endcase
        end else if (r < 72) begin
          op = OP_UP;
        end else if (r < 79) begin
          op = OP_DOWN;
        end else if (r < 86) begin
          op = OP_AUTO;
        end else if (r < 90) begin
          op = op_t'($urandom_range(OP_IGNORED_LO, OP_IGNORED_HI));
        end else begin
          op = op_t'($urandom_range(0, OP_IGNORED_HI));
        end
        stamp = now_run;
        cyc   = cyc_run;
        if (r >= 90) begin
          // noise: fully random fields
          stamp = $urandom;
          cyc   = $urandom;
        end
        send_event(op, stamp, cyc);
        if (op < OP_IGNORED_LO) counted++;
      end
      ev_ch.valid <= 1'b0;
      drain();
    end

    $display("Checked %0d results: %0d frequency updates (%0d saturated), %0d restart pulses,",
             checked, freq_updates, saturations, restarts);
    $display("%0d keys taken, %0d register settings, one %0d-cycle receiver stall.",
             keys_taken, PHASES + 1, HOLD_CYCLES);
    if (errors == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
